@@ rtl/core/two_state_burst_detector_assert.svh @@
// Assertion macros used by the checker file of the burst detector.
`ifndef TWO_STATE_BURST_DETECTOR_ASSERT_SVH
`define TWO_STATE_BURST_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("burst detector check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("burst detector check failed");

`endif

@@ rtl/core/tsbd_pkg.sv @@
// Shared widths, codes and helpers of the two-state burst detector.
package tsbd_pkg;

  localparam int CountW  = 32;
  localparam int SumW    = 38;
  localparam int CfgW    = 16;
  localparam int LnInW   = 54;
  localparam int LnW     = 22;
  localparam int CostW   = 64;
  localparam int WeightW = 40;

  localparam logic [31:0]      Ln2Q32   = 32'd2977044472;
  localparam logic [CostW-1:0] CostInf  = '1;
  localparam logic [CfgW-1:0]  ScaleOne = 16'd256;

  typedef enum logic [1:0] {
    StatusNormal = 2'd0,
    StatusReject = 2'd1,
    StatusSat    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RegScale = 2'd0,
    RegGain  = 2'd1,
    RegCut   = 2'd2
  } reg_idx_e;

  // Add two costs, pin at all ones on carry out
  function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                               input logic [CostW-1:0] b);
    logic [CostW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostW] ? CostInf : s[CostW-1:0];
  endfunction

endpackage

@@ rtl/core/tsbd_in_if.sv @@
// Batch channel: per-batch counts and the window-closing flag.
interface tsbd_in_if import tsbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] total_count;
  logic [CountW-1:0] relevant_count;
  logic              last_batch;

  modport source(output valid, total_count, relevant_count, last_batch, input ready);
  modport sink(input valid, total_count, relevant_count, last_batch, output ready);
endinterface

@@ rtl/core/tsbd_out_if.sv @@
// Result channel: one weight and path state per batch.
interface tsbd_out_if import tsbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WeightW-1:0] batch_weight;
  logic               in_burst;
  logic [1:0]         status;
  logic               last_result;

  modport source(output valid, batch_weight, in_burst, status, last_result, input ready);
  modport sink(input valid, batch_weight, in_burst, status, last_result, output ready);
endinterface

@@ rtl/core/tsbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tsbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/tsbd_ln.sv @@
// Iterative natural log unit: normalize, square for log2 bits, scale by ln 2.
module tsbd_ln import tsbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LnInW-1:0] x_i,
  output logic             done_o,
  output logic [LnW-1:0]   ln_o
);

  typedef enum logic [1:0] {LnIdle, LnNorm, LnSqr, LnScale} ln_state_e;

  ln_state_e   state_q;
  logic [4:0]  step_q;
  logic [63:0] x_q;
  logic [5:0]  k_q;
  logic [31:0] m_q;
  logic [19:0] frac_q;

  logic [5:0]  sh;
  logic        top_zero;
  logic [63:0] x_nx;
  logic [63:0] sq;
  logic [32:0] sq_top;
  logic [25:0] l2;
  logic [57:0] scl;

  // Binary search for the leading one: shift by 32, 16, .. 1
  assign sh       = 6'd32 >> step_q[2:0];
  assign top_zero = (x_q >> (7'd64 - {1'b0, sh})) == 64'd0;
  assign x_nx     = top_zero ? (x_q << sh) : x_q;

  // Square the Q1.31 mantissa
  assign sq     = 64'(m_q) * 64'(m_q);
  assign sq_top = sq[63:31];

  // Scale log2 to ln, round to Q.16
  assign l2  = {k_q, frac_q};
  assign scl = 58'(l2) * 58'(Ln2Q32) + (58'd1 << 35);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LnIdle;
      step_q  <= '0;
      x_q     <= '0;
      k_q     <= '0;
      m_q     <= '0;
      frac_q  <= '0;
      done_o  <= 1'b0;
      ln_o    <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        LnIdle: begin
          if (start_i) begin
            if (x_i == '0) begin
              ln_o   <= '0;
              done_o <= 1'b1;
            end else begin
              x_q     <= 64'(x_i);
              k_q     <= 6'd63;
              step_q  <= '0;
              state_q <= LnNorm;
            end
          end
        end
        LnNorm: begin
          x_q <= x_nx;
          if (top_zero) begin
            k_q <= k_q - sh;
          end
          if (step_q == 5'd5) begin
            m_q     <= x_nx[63:32];
            frac_q  <= '0;
            step_q  <= '0;
            state_q <= LnSqr;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        LnSqr: begin
          // One fraction bit per squaring
          if (sq_top[32]) begin
            m_q    <= sq_top[32:1];
            frac_q <= {frac_q[18:0], 1'b1};
          end else begin
            m_q    <= sq_top[31:0];
            frac_q <= {frac_q[18:0], 1'b0};
          end
          if (step_q == 5'd19) begin
            state_q <= LnScale;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        LnScale: begin
          ln_o    <= scl[57:36];
          done_o  <= 1'b1;
          state_q <= LnIdle;
        end
        default: state_q <= LnIdle;
      endcase
    end
  end

endmodule

@@ rtl/core/two_state_burst_detector.sv @@
// Two-state burst detector over a window of batches.
//
// Batches arrive on batch_i, one per cycle while ready is high. A batch with
// last_batch set, or the batch that fills WINDOW entries, closes the window.
// The block then drops ready and judges the window of n batches: seven
// logarithms in the shared log unit, a Viterbi pass over the batches on one
// shared multiplier, and a traceback. It then emits n results on result_o in
// batch order, each held until the receiver takes it; a rejected, saturated
// or empty window emits its n results without the logarithms or the costing.
// While a result waits for ready, the block holds it and does nothing else.
// After the last result of a window, ready rises again in the next cycle.
// Reset clears the window, the sums and the error flag, and loads the
// register defaults. Registers are to be written over APB only while the
// block is idle; the block itself does not enforce this. They are read while
// each window is judged.
module two_state_burst_detector import tsbd_pkg::*; #(
  parameter int WINDOW = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsbd_in_if.sink           batch_i,
  tsbd_out_if.source        result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int MulW = CountW + LnW;
  localparam int TauW = CfgW + LnW - 8;

  typedef enum logic [4:0] {
    SLoad, SChk, SDecide, SLnGo, SLnWait, SPrep, SCrd, SC0, SC1, SC2, SC3,
    SC4, SC5, SVup, SFin1, SFin2, STbRd, STbWr, SOwt, SSpl, SOut
  } state_e;

  typedef enum logic [1:0] {MNormal, MReject, MSat, MZero} mode_e;

  typedef enum logic [2:0] {LnD, LnD256, LnR, LnDmr, LnScr, LnE, LnN} ln_sel_e;

  // Configuration registers
  logic [CfgW-1:0] scale_q, gain_q, cut_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 16'd512;
      gain_q  <= 16'd256;
      cut_q   <= 16'd256;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        RegScale: scale_q <= pwdata[CfgW-1:0];
        RegGain:  gain_q  <= pwdata[CfgW-1:0];
        RegCut:   cut_q   <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      RegScale: prdata = 32'(scale_q);
      RegGain:  prdata = 32'(gain_q);
      RegCut:   prdata = 32'(cut_q);
      default:  prdata = '0;
    endcase
  end

  // Control state
  state_e          state_q;
  mode_e           mode_q;
  ln_sel_e         ln_sel_q;
  logic [CW-1:0]   cnt_q, n_q;
  logic [AW-1:0]   idx_q;
  logic [SumW-1:0] sumd_q, sumr_q;
  logic            err_q;
  logic            out_phase_q;

  // Result register
  logic [WeightW-1:0] weight_q;
  logic               burst_q;
  logic [1:0]         status_q;
  logic               lastr_q;

  // Datapath registers
  logic [LnInW-1:0] scr_q, e_q;
  logic             inf_q;
  logic [LnW-1:0]   lnd_q, lnd256_q, lnr_q, lndmr_q, lnscr_q, lne_q, lnn_q;
  logic [LnW-1:0]   h0_q, m0_q, h1_q, m1_q;
  logic [TauW-1:0]  tau_q, thr_q;
  logic [CostW-1:0] pc0_q, pc1_q, prc0_q, prc1_q, pt_q, acc_q, c0_q, c1_q;
  logic             pdz_q, frc_q, s_q, st_q;
  logic [CountW-1:0] d_q, r_q, q_q;
  logic [MulW-1:0]  prod_q;

  // Combinational helpers
  logic             in_acc, last_idx, bad_cfg;
  logic [LnInW-1:0] d256, ln_x;
  logic [CountW-1:0] mul_a;
  logic [LnW-1:0]   mul_b;
  logic [CostW-1:0] prod64, thr64, tau64, n0, n1, w, diff;
  logic             sel0, sel1, frc_prev, w_over;
  logic [CfgW+LnW-1:0] tau_prod, thr_prod;
  logic             ln_done;
  logic [LnW-1:0]   ln_res;
  logic [2*CountW-1:0] data_rd;
  logic [1:0]       bp_rd, bp_wd;
  logic             bp_we;

  assign in_acc   = batch_i.valid & batch_i.ready;
  assign last_idx = (CW'(idx_q) + CW'(1)) == n_q;
  assign bad_cfg  = err_q || (gain_q == '0) || (scale_q <= ScaleOne) || (cut_q == '0);
  assign d256     = LnInW'({sumd_q, 8'd0});
  assign prod64   = CostW'(prod_q);
  assign thr64    = CostW'(thr_q);
  assign tau64    = CostW'(tau_q);
  assign tau_prod = (CfgW+LnW)'(gain_q) * (CfgW+LnW)'(lnn_q);
  assign thr_prod = (CfgW+LnW)'(cut_q) * (CfgW+LnW)'(lnn_q);

  assign batch_i.ready         = (state_q == SLoad);
  assign result_o.valid        = (state_q == SOut);
  assign result_o.batch_weight = weight_q;
  assign result_o.in_burst     = burst_q;
  assign result_o.status       = status_q;
  assign result_o.last_result  = lastr_q;

  // Log argument select
  always_comb begin
    case (ln_sel_q)
      LnD:     ln_x = LnInW'(sumd_q);
      LnD256:  ln_x = d256;
      LnR:     ln_x = LnInW'(sumr_q);
      LnDmr:   ln_x = LnInW'(sumd_q - sumr_q);
      LnScr:   ln_x = scr_q;
      LnE:     ln_x = e_q;
      LnN:     ln_x = LnInW'(n_q);
      default: ln_x = '0;
    endcase
  end

  // Shared cost multiplier operands
  always_comb begin
    case (state_q)
      SC1:     begin mul_a = r_q; mul_b = h0_q; end
      SC2:     begin mul_a = q_q; mul_b = m0_q; end
      SC3:     begin mul_a = r_q; mul_b = h1_q; end
      SC4:     begin mul_a = q_q; mul_b = m1_q; end
      default: begin mul_a = '0;  mul_b = '0;   end
    endcase
  end

  // Path update, branch cut and weight
  assign sel0     = !frc_q && (pc0_q > pc1_q);
  assign sel1     = !frc_q && (pt_q > pc1_q);
  assign n0       = sat_add(sel0 ? pc1_q : pc0_q, c0_q);
  assign n1       = sat_add(sel1 ? pc1_q : pt_q, c1_q);
  assign frc_prev = pdz_q || (prc1_q > sat_add(prc0_q, thr64));
  assign diff     = c0_q - c1_q;
  assign w        = (st_q && (c0_q > c1_q)) ? diff : '0;
  assign w_over   = |w[CostW-1:WeightW];

  // Back pointer and path state store
  assign bp_we = (state_q == SVup) || (state_q == STbWr);
  assign bp_wd = (state_q == SVup) ? {sel1, sel0} : {1'b0, s_q};

  tsbd_ram #(.Width(2 * CountW), .Depth(WINDOW)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({batch_i.total_count, batch_i.relevant_count}),
    .raddr_i (idx_q),
    .rdata_o (data_rd)
  );

  tsbd_ram #(.Width(2), .Depth(WINDOW)) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (bp_we),
    .waddr_i (idx_q),
    .wdata_i (bp_wd),
    .raddr_i (idx_q),
    .rdata_o (bp_rd)
  );

  tsbd_ln u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == SLnGo),
    .x_i     (ln_x),
    .done_o  (ln_done),
    .ln_o    (ln_res)
  );

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SLoad;
      mode_q      <= MNormal;
      ln_sel_q    <= LnD;
      cnt_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      sumd_q      <= '0;
      sumr_q      <= '0;
      err_q       <= 1'b0;
      out_phase_q <= 1'b0;
      weight_q    <= '0;
      burst_q     <= 1'b0;
      status_q    <= StatusNormal;
      lastr_q     <= 1'b0;
    end else begin
      case (state_q)
        SLoad: begin
          if (in_acc) begin
            sumd_q <= sumd_q + SumW'(batch_i.total_count);
            sumr_q <= sumr_q + SumW'(batch_i.relevant_count);
            if (batch_i.relevant_count > batch_i.total_count) begin
              err_q <= 1'b1;
            end
            if (batch_i.last_batch || (cnt_q == CW'(WINDOW - 1))) begin
              n_q     <= cnt_q + CW'(1);
              cnt_q   <= '0;
              state_q <= SChk;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        SChk: state_q <= SDecide;
        SDecide: begin
          idx_q <= '0;
          if (bad_cfg) begin
            mode_q  <= MReject;
            state_q <= SSpl;
          end else if (scr_q > d256) begin
            mode_q  <= MSat;
            state_q <= SSpl;
          end else if (sumr_q == '0) begin
            mode_q  <= MZero;
            state_q <= SSpl;
          end else begin
            mode_q   <= MNormal;
            ln_sel_q <= LnD;
            state_q  <= SLnGo;
          end
        end
        SLnGo: state_q <= SLnWait;
        SLnWait: begin
          if (ln_done) begin
            if (ln_sel_q == LnN) begin
              state_q <= SPrep;
            end else begin
              ln_sel_q <= ln_sel_e'(ln_sel_q + 3'd1);
              state_q  <= SLnGo;
            end
          end
        end
        SPrep: begin
          idx_q       <= '0;
          out_phase_q <= 1'b0;
          state_q     <= SCrd;
        end
        SCrd: state_q <= SC0;
        SC0:  state_q <= SC1;
        SC1:  state_q <= SC2;
        SC2:  state_q <= SC3;
        SC3:  state_q <= SC4;
        SC4:  state_q <= SC5;
        SC5:  state_q <= out_phase_q ? SOwt : SVup;
        SVup: begin
          if (last_idx) begin
            state_q <= SFin1;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= SCrd;
          end
        end
        SFin1: state_q <= SFin2;
        SFin2: state_q <= STbRd;
        STbRd: state_q <= STbWr;
        STbWr: begin
          if (idx_q == '0) begin
            out_phase_q <= 1'b1;
            state_q     <= SCrd;
          end else begin
            idx_q   <= idx_q - AW'(1);
            state_q <= STbRd;
          end
        end
        SOwt: begin
          weight_q <= w_over ? '1 : w[WeightW-1:0];
          burst_q  <= st_q;
          status_q <= w_over ? StatusSat : StatusNormal;
          lastr_q  <= last_idx;
          state_q  <= SOut;
        end
        SSpl: begin
          case (mode_q)
            MReject: begin
              weight_q <= '0;
              burst_q  <= 1'b0;
              status_q <= StatusReject;
            end
            MSat: begin
              weight_q <= '1;
              burst_q  <= 1'b1;
              status_q <= StatusSat;
            end
            default: begin
              weight_q <= '0;
              burst_q  <= 1'b0;
              status_q <= StatusNormal;
            end
          endcase
          lastr_q <= last_idx;
          state_q <= SOut;
        end
        SOut: begin
          if (result_o.ready) begin
            if (last_idx) begin
              sumd_q  <= '0;
              sumr_q  <= '0;
              err_q   <= 1'b0;
              state_q <= SLoad;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= (mode_q == MNormal) ? SCrd : SSpl;
            end
          end
        end
        default: state_q <= SLoad;
      endcase
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk_i) begin
    prod_q <= MulW'(mul_a) * MulW'(mul_b);
    case (state_q)
      SChk: scr_q <= LnInW'(scale_q) * LnInW'(sumr_q);
      SDecide: begin
        e_q   <= d256 - scr_q;
        inf_q <= (d256 == scr_q);
      end
      SLnWait: begin
        if (ln_done) begin
          case (ln_sel_q)
            LnD:     lnd_q    <= ln_res;
            LnD256:  lnd256_q <= ln_res;
            LnR:     lnr_q    <= ln_res;
            LnDmr:   lndmr_q  <= ln_res;
            LnScr:   lnscr_q  <= ln_res;
            LnE:     lne_q    <= ln_res;
            default: lnn_q    <= ln_res;
          endcase
        end
      end
      SPrep: begin
        h0_q  <= lnd_q - lnr_q;
        m0_q  <= lnd_q - lndmr_q;
        h1_q  <= lnd256_q - lnscr_q;
        m1_q  <= inf_q ? '0 : (lnd256_q - lne_q);
        tau_q <= tau_prod[CfgW+LnW-1:8];
        thr_q <= thr_prod[CfgW+LnW-1:8];
        pc0_q <= '0;
        pc1_q <= CostInf;
      end
      SC0: begin
        // Latch the batch, cut test on the batch before it
        d_q   <= data_rd[2*CountW-1:CountW];
        r_q   <= data_rd[CountW-1:0];
        q_q   <= data_rd[2*CountW-1:CountW] - data_rd[CountW-1:0];
        st_q  <= bp_rd[0];
        frc_q <= (idx_q != '0) && frc_prev;
        pt_q  <= sat_add(pc0_q, tau64);
      end
      SC2: acc_q <= prod64;
      SC3: c0_q  <= (q_q != '0) ? sat_add(acc_q, prod64) : acc_q;
      SC4: acc_q <= prod64;
      SC5: begin
        if (q_q == '0) begin
          c1_q <= acc_q;
        end else begin
          c1_q <= inf_q ? CostInf : sat_add(acc_q, prod64);
        end
      end
      SVup: begin
        pc0_q  <= n0;
        pc1_q  <= n1;
        prc0_q <= c0_q;
        prc1_q <= c1_q;
        pdz_q  <= (d_q == '0);
      end
      SFin1: frc_q <= frc_prev;
      SFin2: s_q   <= !(frc_q || (pc0_q <= pc1_q));
      STbWr: s_q   <= bp_rd[s_q];
      default: ;
    endcase
  end

endmodule

@@ rtl/core/tsbd_checker.sv @@
// Port-level checks of the burst detector, bound to the top level.
`include "two_state_burst_detector_assert.svh"

module tsbd_checker import tsbd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [WeightW-1:0] weight_i,
  input logic               in_burst_i,
  input logic [1:0]         status_i,
  input logic               last_i
);

  // No batch is taken while a result is pending
  `TSBD_ASSERT_IMP(a_no_load_on_result, out_valid_i, !in_ready_i)

  // A stalled result holds
  `TSBD_ASSERT_NXT(a_hold_stalled, out_valid_i && !out_ready_i, out_valid_i && $stable(weight_i) && $stable(status_i))

  // Rejected windows carry no weight and no burst
  `TSBD_ASSERT_IMP(a_reject_clean, out_valid_i && status_i == StatusReject, weight_i == '0 && !in_burst_i)

  // Saturated results are full-scale bursts
  `TSBD_ASSERT_IMP(a_sat_burst, out_valid_i && status_i == StatusSat, in_burst_i && weight_i == '1)

  // The window's final transfer reopens loading
  `TSBD_ASSERT_NXT(a_reopen, out_valid_i && out_ready_i && last_i, !out_valid_i && in_ready_i)

endmodule

bind two_state_burst_detector tsbd_checker u_tsbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (batch_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .weight_i    (result_o.batch_weight),
  .in_burst_i  (result_o.in_burst),
  .status_i    (result_o.status),
  .last_i      (result_o.last_result)
);
